@@ sv/fpfd_pkg.sv @@
// Shared constants and pipeline payload type for the fixed-point fraction divider.
package fpfd_pkg;

    localparam int DIVIDEND_BITS   = 32;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = (DIVIDEND_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int WORK_BITS       = NUM_STAGES * STEPS_PER_STAGE;
    localparam int SCALE_SHIFT     = 4;
    localparam int DIVISOR_LSB     = 12;
    localparam int DIVISOR_BITS    = 16;
    localparam int IN_BITS         = 32;
    localparam int OUT_BITS        = 32;

    typedef struct packed {
        logic [DIVISOR_BITS-1:0] divisor;
        logic [DIVISOR_BITS-1:0] rem;
        logic [WORK_BITS-1:0]    work;
        logic                    div_zero;
    } fpfd_data_t;

endpackage

@@ sv/fpfd_prep.sv @@
// Input register stage: forms the scaled dividend and the integer divisor.
module fpfd_prep
    import fpfd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_BITS-1:0]  s_numerator,
    input  logic [IN_BITS-1:0]  s_denominator,
    output logic                dn_valid,
    input  logic                dn_ready,
    output fpfd_data_t          dn_data
);

    logic                    valid_reg;
    fpfd_data_t              data_reg;
    fpfd_data_t              data_next;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVISOR_BITS-1:0] divisor;

    assign s_ready  = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        dividend = DIVIDEND_BITS'({s_numerator, {SCALE_SHIFT{1'b0}}});
        divisor  = s_denominator[DIVISOR_LSB +: DIVISOR_BITS];
        data_next.divisor  = divisor;
        data_next.rem      = '0;
        data_next.work     = WORK_BITS'(dividend);
        data_next.div_zero = (divisor == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/fpfd_stage.sv @@
// One divider pipeline stage: STEPS_PER_STAGE restoring division steps and a register.
module fpfd_stage
    import fpfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       up_valid,
    output logic       up_ready,
    input  fpfd_data_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output fpfd_data_t dn_data
);

    logic       valid_reg;
    fpfd_data_t data_reg;
    fpfd_data_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        logic [DIVISOR_BITS:0]   trial;
        logic [DIVISOR_BITS-1:0] rem;
        logic [WORK_BITS-1:0]    work;
        rem   = up_data.rem;
        work  = up_data.work;
        trial = '0;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            trial = {rem, work[WORK_BITS-1]};
            work  = {work[WORK_BITS-2:0], 1'b0};
            if (trial >= {1'b0, up_data.divisor}) begin
                trial   = trial - {1'b0, up_data.divisor};
                work[0] = 1'b1;
            end
            rem = trial[DIVISOR_BITS-1:0];
        end
        data_next          = up_data;
        data_next.rem      = rem;
        data_next.work     = work;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ sv/fpfd_round.sv @@
// Output register stage: rounds the quotient and substitutes the zero-divisor result.
module fpfd_round
    import fpfd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                up_valid,
    output logic                up_ready,
    input  fpfd_data_t          up_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_BITS-1:0] m_quotient,
    output logic                m_divide_by_zero
);

    logic                valid_reg;
    logic [OUT_BITS-1:0] quotient_reg;
    logic [OUT_BITS-1:0] quotient_next;
    logic                dz_reg;
    logic                round_up;
    logic [WORK_BITS:0]  sum;

    assign up_ready         = !valid_reg || m_ready;
    assign m_valid          = valid_reg;
    assign m_quotient       = quotient_reg;
    assign m_divide_by_zero = dz_reg;

    always_comb begin
        round_up = ({up_data.rem, 1'b0} >= {1'b0, up_data.divisor});
        sum      = {1'b0, up_data.work} + (WORK_BITS + 1)'(round_up);
        if (up_data.div_zero) begin
            quotient_next = '1;
        end else begin
            quotient_next = OUT_BITS'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && up_valid) begin
            quotient_reg <= quotient_next;
            dz_reg       <= up_data.div_zero;
        end
    end

endmodule

@@ sv/fixed_point_fraction_divider_core.sv @@
// Top level of the pipelined Q12 by Q12 to Q16 rounded fraction divider.
//
//  channel | direction | fields                          | handshake
//  s_      | in        | s_numerator, s_denominator      | s_valid / s_ready
//  m_      | out       | m_quotient, m_divide_by_zero    | m_valid / m_ready
//
// One beat is accepted per cycle while the output is not stalled; each beat passes
// through an input register, NUM_STAGES stages of four restoring steps each,
// and a rounding output register.
// Reset clears only the stage valid bits; the block is ready the cycle after.
// Each stage holds its beat while the next one is full and stalled, so a stall
// at the output fills empty stages first and only then backs up to s_ready.
module fixed_point_fraction_divider_core
    import fpfd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [IN_BITS-1:0]  s_numerator,
    input  logic [IN_BITS-1:0]  s_denominator,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_BITS-1:0] m_quotient,
    output logic                m_divide_by_zero
);

    logic       pipe_valid [NUM_STAGES+1];
    logic       pipe_ready [NUM_STAGES+1];
    fpfd_data_t pipe_data  [NUM_STAGES+1];

    fpfd_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_numerator   (s_numerator),
        .s_denominator (s_denominator),
        .dn_valid      (pipe_valid[0]),
        .dn_ready      (pipe_ready[0]),
        .dn_data       (pipe_data[0])
    );

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        fpfd_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (pipe_valid[g]),
            .up_ready (pipe_ready[g]),
            .up_data  (pipe_data[g]),
            .dn_valid (pipe_valid[g+1]),
            .dn_ready (pipe_ready[g+1]),
            .dn_data  (pipe_data[g+1])
        );
    end

    fpfd_round u_round (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .up_valid         (pipe_valid[NUM_STAGES]),
        .up_ready         (pipe_ready[NUM_STAGES]),
        .up_data          (pipe_data[NUM_STAGES]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quotient       (m_quotient),
        .m_divide_by_zero (m_divide_by_zero)
    );

endmodule

@@ sv/fpfd_checker.sv @@
// Port-level checker for the fraction divider, bound to the top level.
module fpfd_checker
    import fpfd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [OUT_BITS-1:0] m_quotient,
    input logic                m_divide_by_zero
);

    // A held result beat must not change while the sink stalls.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient) && $stable(m_divide_by_zero))
        else $error("result beat changed or dropped during stall");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A free output stage means every stage can advance.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while output side can drain");

    // A zero divisor always reports the saturated quotient.
    a_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_quotient == '1)
        else $error("zero divisor without all-ones quotient");

endmodule

bind fixed_point_fraction_divider_core fpfd_checker u_fpfd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_quotient       (m_quotient),
    .m_divide_by_zero (m_divide_by_zero)
);

@@ bench/fixed_point_fraction_divider_core_tb.sv @@
// Self-checking bench for the pipelined Q12 by Q12 to Q16 rounded fraction divider.
`timescale 1ns / 100ps

module fixed_point_fraction_divider_core_tb;
    import fpfd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_START     = 400;
    localparam int HOLD_CYCLES    = 250;

    typedef struct packed {
        logic [IN_BITS-1:0] numerator;
        logic [IN_BITS-1:0] denominator;
    } operand_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] quotient;
        logic                divide_by_zero;
    } ratio_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [IN_BITS-1:0]  s_numerator = '0;
    logic [IN_BITS-1:0]  s_denominator = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OUT_BITS-1:0] m_quotient;
    logic                m_divide_by_zero;

    operand_t operand_queue[$];
    ratio_t   expected_ratios[$];

    int cycle_count = 0;
    int ratios_checked = 0;
    int zero_divisor_count = 0;
    int mismatch_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int recv_cycle = 0;
    int recv_mode = 0;
    bit hold_done = 1'b0;

    fixed_point_fraction_divider_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_numerator      (s_numerator),
        .s_denominator    (s_denominator),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_quotient       (m_quotient),
        .m_divide_by_zero (m_divide_by_zero)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Restoring division with a remainder two bits wider than the divisor.
    function automatic ratio_t predict_ratio(logic [IN_BITS-1:0] num,
                                             logic [IN_BITS-1:0] den);
        logic [63:0]             dividend;
        logic [63:0]             quo;
        logic [DIVISOR_BITS-1:0] divisor;
        logic [DIVISOR_BITS+1:0] part;
        ratio_t                  r;
        dividend = {32'b0, num} << SCALE_SHIFT;
        if (DIVIDEND_BITS < 64) begin
            dividend = dividend & ((64'd1 << DIVIDEND_BITS) - 64'd1);
        end
        divisor = den[DIVISOR_LSB +: DIVISOR_BITS];
        quo = '0;
        part = '0;
        if (divisor == '0) begin
            r.quotient = '1;
            r.divide_by_zero = 1'b1;
            return r;
        end
        for (int i = DIVIDEND_BITS - 1; i >= 0; i--) begin
            part = {part[DIVISOR_BITS:0], dividend[i]};
            if (part >= {2'b00, divisor}) begin
                part = part - {2'b00, divisor};
                quo[i] = 1'b1;
            end
        end
        if ({part, 1'b0} >= {3'b000, divisor}) begin
            quo = quo + 64'd1;
        end
        r.quotient = quo[OUT_BITS-1:0];
        r.divide_by_zero = 1'b0;
        return r;
    endfunction

    task automatic add_operand(logic [IN_BITS-1:0] num, logic [IN_BITS-1:0] den);
        operand_t op;
        op.numerator = num;
        op.denominator = den;
        operand_queue.push_back(op);
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        operand_t op;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_ratios.push_back(predict_ratio(s_numerator, s_denominator));
                if (s_denominator[DIVISOR_LSB +: DIVISOR_BITS] == '0) begin
                    zero_divisor_count++;
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (operand_queue.size() > 0) begin
                op = operand_queue.pop_front();
                s_valid <= 1'b1;
                s_numerator <= op.numerator;
                s_denominator <= op.denominator;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern, redrawn at random from four modes, plus one long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            recv_cycle++;
            if (recv_cycle % 64 == 0) begin
                recv_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && recv_cycle >= HOLD_START) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                case (recv_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready <= (recv_cycle % 3 == 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 7) != 0);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        ratio_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ratios.size() == 0) begin
                $display("%0t: unexpected beat, quotient %h divide_by_zero %b",
                         $time, m_quotient, m_divide_by_zero);
                mismatch_count++;
            end else begin
                exp_r = expected_ratios.pop_front();
                ratios_checked++;
                if (m_quotient !== exp_r.quotient) begin
                    $display("%0t: quotient expected %h actual %h",
                             $time, exp_r.quotient, m_quotient);
                    mismatch_count++;
                end
                if (m_divide_by_zero !== exp_r.divide_by_zero) begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, exp_r.divide_by_zero, m_divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats still expected",
                     $time, expected_ratios.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [IN_BITS-1:0] num;
        logic [IN_BITS-1:0] den;

        add_operand(32'h0000_0000, 32'h0000_1000);
        add_operand(32'hFFFF_FFFF, 32'h0000_1000);
        add_operand(32'hFFFF_FFFF, 32'h0FFF_F000);
        add_operand(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_operand(32'h8000_0000, 32'h0800_0000);
        add_operand(32'h1000_0000, 32'h0000_1000);
        add_operand(32'h0FFF_FFFF, 32'h0000_1000);
        add_operand(32'h1234_5678, 32'h0000_0000);
        add_operand(32'hFFFF_FFFF, 32'hF000_0FFF);
        add_operand(32'h0000_0001, 32'h0002_0000);
        add_operand(32'h0000_0001, 32'h0002_1000);
        add_operand(32'h0000_0001, 32'h0000_3000);
        add_operand(32'h7FFF_FFFF, 32'h07FF_F000);
        add_operand(32'hFFFF_FFFF, 32'h0800_1000);
        add_operand(32'hABCD_EF01, 32'hF800_1FFF);
        add_operand(32'h0000_1000, 32'h0000_1000);
        add_operand(32'h0FFF_F000, 32'h0FFF_F000);
        add_operand(32'h5555_5555, 32'h0AAA_A000);
        add_operand(32'hAAAA_AAAA, 32'h0555_5FFF);
        add_operand(32'h0000_0000, 32'h0000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ($urandom_range(0, 3))
                0: num = $urandom_range(0, 65535);
                1: num = 32'hFFFF_FFFF - $urandom_range(0, 65535);
                default: num = $urandom;
            endcase
            den = $urandom;
            case ($urandom_range(0, 9))
                0: den[DIVISOR_LSB +: DIVISOR_BITS] = '0;
                1, 2: den[DIVISOR_LSB +: DIVISOR_BITS] = 16'($urandom_range(1, 255));
                3, 4: den[DIVISOR_LSB +: DIVISOR_BITS] = 16'($urandom_range(32768, 65535));
                5: den[DIVISOR_LSB +: DIVISOR_BITS] = 16'(32'hFFFF - $urandom_range(0, 3));
                default: ;
            endcase
            add_operand(num, den);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (operand_queue.size() > 0 || s_valid || expected_ratios.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d quotients, %0d of them with a zero integer divisor,",
                 ratios_checked, zero_divisor_count);
        $display("over %0d cycles with bursty input and a long output hold-off.",
                 cycle_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/fpfd_pkg.sv
sv/fpfd_prep.sv
sv/fpfd_stage.sv
sv/fpfd_round.sv
sv/fixed_point_fraction_divider_core.sv
sv/fpfd_checker.sv
bench/fixed_point_fraction_divider_core_tb.sv
